FILE: sv/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Beat types, register indexes, result kinds and frame constants shared by
// the decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

  // Frame geometry
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);
  localparam int unsigned BYTE_W     = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_BOUNDARY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_BOUNDARY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_MODE   = 2'd2;

  // Register reset values
  localparam logic [15:0] BIT_BOUNDARY_RST    = 16'd1680;
  localparam logic [15:0] LEADER_BOUNDARY_RST = 16'd12500;
  localparam logic        EXTENDED_MODE_RST   = 1'b1;

  // Input actions
  localparam logic ACT_ARM    = 1'b0;
  localparam logic ACT_PERIOD = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_VALID  = 2'd0;
  localparam logic [1:0] KIND_REPEAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Result words for repeat and error
  localparam logic [FRAME_BITS-1:0] WORD_REPEAT = '1;
  localparam logic [FRAME_BITS-1:0] WORD_ERROR  = '0;

  typedef struct packed {
    logic        action;
    logic [15:0] period_ticks;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]            frame_kind;
    logic [FRAME_BITS-1:0] frame_word;
  } out_beat_t;

endpackage

FILE: sv/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Turns captured edge-to-edge periods into NEC frame words, repeat codes or
// check errors.
// ----------------------------------------------------------------------------
// The decoder takes one beat per cycle: every accepted beat updates the phase,
// the capture counter and the bit shifter in the same clock, and any result
// it causes lands in the output register on that edge, shown on out_valid_o in
// the next cycle. Input ready is high while the output register is empty or
// being drained, so a held result stalls input only when it is not taken.
// An arm beat (action 0) restarts the header phase and gives no result. In
// the header phase the first period is dropped; the second one below
// leader_boundary yields a repeat code (all-ones word), otherwise the data
// phase collects FRAME_BITS periods, each above bit_boundary being a one,
// packed LSB first. After the last bit the command byte must match its
// inverse, and with extended_mode clear the address byte too; the frame word
// or an all-zeros error beat is emitted and the decoder goes idle. Periods
// seen while idle are dropped. Configuration writes are registered; the user
// must make them only while the decoder is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nec_ir_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input beats
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  nec_ir_pkg::in_beat_t                 in_data_i,
  // result beats
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output nec_ir_pkg::out_beat_t                out_data_o
);

  // Phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  localparam int unsigned FB = nec_ir_pkg::FRAME_BITS;
  localparam int unsigned BW = nec_ir_pkg::BYTE_W;

  // Configuration registers
  logic [15:0] bit_boundary_q;
  logic [15:0] leader_boundary_q;
  logic        extended_mode_q;

  // Decoder state
  logic [1:0]                    phase_q, phase_d;
  logic [nec_ir_pkg::CNT_W-1:0]  count_q, count_d;
  logic [FB-1:0]                 shift_q, shift_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  nec_ir_pkg::out_beat_t out_data_q, out_data_d;

  logic          in_fire;
  logic          res_fire;
  logic [FB-1:0] word_full;
  logic          is_one;
  logic          last_bit;
  logic          addr_ok;
  logic          cmd_ok;

  // Accept while the result slot is free or being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_one   = in_data_i.period_ticks > bit_boundary_q;
  assign last_bit = (count_q == nec_ir_pkg::CNT_W'(FB - 1));

  // Frame word with the current bit dropped into place.
  always_comb begin
    word_full          = shift_q;
    word_full[count_q] = is_one;
  end

  // Byte checks: address/inverse in bytes 0/1, command/inverse in bytes 2/3.
  assign addr_ok = word_full[2*BW-1:BW]   == ~word_full[BW-1:0];
  assign cmd_ok  = word_full[4*BW-1:3*BW] == ~word_full[3*BW-1:2*BW];

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    shift_d    = shift_q;
    res_fire   = 1'b0;
    out_data_d = out_data_q;

    if (in_fire) begin
      if (in_data_i.action == nec_ir_pkg::ACT_ARM) begin
        phase_d = PH_HEADER;
        count_d = '0;
        shift_d = '0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (count_q == '0) begin
              // drop the leading burst period
              count_d = nec_ir_pkg::CNT_W'(1);
            end else begin
              count_d = '0;
              shift_d = '0;
              if (in_data_i.period_ticks < leader_boundary_q) begin
                phase_d               = PH_IDLE;
                res_fire              = 1'b1;
                out_data_d.frame_kind = nec_ir_pkg::KIND_REPEAT;
                out_data_d.frame_word = nec_ir_pkg::WORD_REPEAT;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            shift_d = word_full;
            count_d = count_q + nec_ir_pkg::CNT_W'(1);
            if (last_bit) begin
              phase_d  = PH_IDLE;
              count_d  = '0;
              res_fire = 1'b1;
              if (cmd_ok && (extended_mode_q || addr_ok)) begin
                out_data_d.frame_kind = nec_ir_pkg::KIND_VALID;
                out_data_d.frame_word = word_full;
              end else begin
                out_data_d.frame_kind = nec_ir_pkg::KIND_ERROR;
                out_data_d.frame_word = nec_ir_pkg::WORD_ERROR;
              end
            end
          end
          default: begin
            // idle: drop the period
          end
        endcase
      end
    end
  end

  // Hold the result until taken; a new result may replace a drained one.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_boundary_q    <= nec_ir_pkg::BIT_BOUNDARY_RST;
      leader_boundary_q <= nec_ir_pkg::LEADER_BOUNDARY_RST;
      extended_mode_q   <= nec_ir_pkg::EXTENDED_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nec_ir_pkg::CFG_BIT_BOUNDARY:    bit_boundary_q    <= cfg_wdata_i;
        nec_ir_pkg::CFG_LEADER_BOUNDARY: leader_boundary_q <= cfg_wdata_i;
        nec_ir_pkg::CFG_EXTENDED_MODE:   extended_mode_q   <= cfg_wdata_i[0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      shift_q     <= shift_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
